FILE: rtl/ebcpu_pkg.sv
// shared types, codes and flag helpers of the 8-bit cpu arithmetic group
`default_nettype none

package ebcpu_pkg;

   // instruction codes
   localparam logic [3:0] OP_ADD = 4'd0;
   localparam logic [3:0] OP_ADC = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_SBB = 4'd3;
   localparam logic [3:0] OP_ADI = 4'd4;
   localparam logic [3:0] OP_ACI = 4'd5;
   localparam logic [3:0] OP_SUI = 4'd6;
   localparam logic [3:0] OP_SBI = 4'd7;
   localparam logic [3:0] OP_INR = 4'd8;
   localparam logic [3:0] OP_DCR = 4'd9;
   localparam logic [3:0] OP_INX = 4'd10;
   localparam logic [3:0] OP_DCX = 4'd11;
   localparam logic [3:0] OP_DAD = 4'd12;
   localparam logic [3:0] OP_DAA = 4'd13;

   // operand register codes with a meaning of their own
   localparam logic [2:0] SEL_M = 3'd6;
   localparam logic [2:0] SEL_A = 3'd7;

   // register pair codes
   localparam logic [1:0] PAIR_HL  = 2'd2;
   localparam logic [1:0] PAIR_BAD = 2'd3;

   // rows of the pair memory: bc, de, hl
   localparam int PAIR_ROWS = 3;

   // flag bit positions
   localparam int FLAG_S  = 4;
   localparam int FLAG_Z  = 3;
   localparam int FLAG_AC = 2;
   localparam int FLAG_P  = 1;
   localparam int FLAG_CY = 0;

   typedef struct packed {
      logic [3:0] op;
      logic [2:0] reg_sel;
      logic [1:0] pair_sel;
      logic [7:0] immediate;
      logic [7:0] mem_data;
   } req_item_type;

   typedef struct packed {
      req_item_type req;
      logic [7:0]   acc;
      logic [4:0]   flags;
      logic [15:0]  row_data;
      logic [15:0]  hl;
   } alu_in_type;

   typedef struct packed {
      logic [7:0]  acc;
      logic [4:0]  flags;
      logic [15:0] hl;
      logic        row_we;
      logic [1:0]  row_addr;
      logic [15:0] row_data;
      logic        mem_write;
      logic [7:0]  mem_wdata;
      logic        error;
   } alu_out_type;

   // sign, zero and even parity of a result byte
   function automatic logic [4:0] szp_flags(input logic [7:0] v);
      logic [4:0] f;
      f = '0;
      f[FLAG_S] = v[7];
      f[FLAG_Z] = (v == 8'h00);
      f[FLAG_P] = ~^v;
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/eight_bit_cpu_arith_group.sv
// top level of the 8-bit cpu arithmetic group: pair memory, pipeline and result register
//
// channel   dir   handshake            payload
// req_      in    req_tvalid/tready    req_tdata  (instruction item)
// rsp_      out   rsp_tvalid/tready    rsp_tdata  (result item)
//
// one item per cycle while rsp_ is not stalled; a result shows on rsp_ once its item has passed
// stage one (item and bc/de/hl pair memory read registered) and been executed and written back
// a pair written by one item and read by the next is forwarded around the memory
// synchronous reset clears a, flags, the hl copy, the pair row and pipeline valid bits
// a stalled result holds in the output register while one more item is taken
`default_nettype none

module eight_bit_cpu_arith_group (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_type[3:0], reg_sel[6:4], pair_sel[8:7], immediate[16:9], mem_data[24:17]
   input  wire logic [31:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // acc_out[7:0], flags_out[12:8], mem_write[13], mem_wdata[21:14],
   // hl_addr[37:22], error[38]
   output logic [39:0]      rsp_tdata
);

   // bc, de and hl rows, b/d/h in the high byte
   logic [15:0] pair_mem [ebcpu_pkg::PAIR_ROWS];

   logic                         req_accept;
   ebcpu_pkg::req_item_type      req_item;
   logic [1:0]                   rd_row;
   logic                         rd_en;
   logic                         wr_en;
   logic                         s1_fire;

   // stage one: item waiting on its memory read
   logic                         s1_valid_ff;
   ebcpu_pkg::req_item_type      s1_req_ff;
   logic [15:0]                  rd_data_ff;
   logic                         rd_vld_ff;
   logic                         byp_hit_ff;
   logic [15:0]                  byp_data_ff;
   logic [ebcpu_pkg::PAIR_ROWS-1:0] row_vld_ff;

   // architectural state held in flops
   logic [7:0]                   acc_ff;
   logic [4:0]                   flags_ff;
   logic [15:0]                  hl_ff;

   // output register
   logic                         rsp_valid_ff;
   logic [39:0]                  rsp_data_ff;
   logic [39:0]                  rsp_data_in;

   logic [15:0]                  row_q;
   ebcpu_pkg::alu_in_type        alu_in;
   ebcpu_pkg::alu_out_type       alu_out;

   assign req_item.op        = req_tdata[3:0];
   assign req_item.reg_sel   = req_tdata[6:4];
   assign req_item.pair_sel  = req_tdata[8:7];
   assign req_item.immediate = req_tdata[16:9];
   assign req_item.mem_data  = req_tdata[24:17];

   // stage one moves on when the output register is free or being drained
   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;

   // pair ops address by pair_sel, register ops by the register's row
   always_comb begin
      if ((req_item.op == ebcpu_pkg::OP_INX) || (req_item.op == ebcpu_pkg::OP_DCX) ||
          (req_item.op == ebcpu_pkg::OP_DAD)) begin
         rd_row = req_item.pair_sel;
      end else begin
         rd_row = req_item.reg_sel[2:1];
      end
   end

   // m, a and the illegal pair have no row
   assign rd_en = req_accept && (rd_row != ebcpu_pkg::PAIR_BAD);
   assign wr_en = s1_fire && alu_out.row_we;

   // forwarded row beats the memory, a never written row reads as zero
   assign row_q = byp_hit_ff ? byp_data_ff : (rd_vld_ff ? rd_data_ff : 16'h0000);

   assign alu_in.req      = s1_req_ff;
   assign alu_in.acc      = acc_ff;
   assign alu_in.flags    = flags_ff;
   assign alu_in.row_data = row_q;
   assign alu_in.hl       = hl_ff;

   ebcpu_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   assign rsp_data_in = {1'b0, alu_out.error, alu_out.hl, alu_out.mem_wdata,
                         alu_out.mem_write, alu_out.flags, alu_out.acc};

   // pair memory, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_mem[alu_out.row_addr] <= alu_out.row_data;
      end
      if (rd_en) begin
         rd_data_ff  <= pair_mem[rd_row];
         byp_data_ff <= alu_out.row_data;
      end
   end

   // pipeline control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         byp_hit_ff   <= 1'b0;
         row_vld_ff   <= '0;
         acc_ff       <= 8'h00;
         flags_ff     <= 5'h00;
         hl_ff        <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (rd_en) begin
            rd_vld_ff  <= row_vld_ff[rd_row];
            // the row being written this edge is read stale, so keep the new value
            byp_hit_ff <= wr_en && (alu_out.row_addr == rd_row);
         end
         if (wr_en) begin
            row_vld_ff[alu_out.row_addr] <= 1'b1;
         end
         if (s1_fire) begin
            acc_ff   <= alu_out.acc;
            flags_ff <= alu_out.flags;
            hl_ff    <= alu_out.hl;
         end
         if (s1_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_item;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/ebcpu_alu.sv
// execute unit: next accumulator, flags, pair row and memory write of one item
`default_nettype none

module ebcpu_alu (
   input  ebcpu_pkg::alu_in_type  alu_in,
   output ebcpu_pkg::alu_out_type alu_out
);

   logic [7:0]  src_reg;
   logic [7:0]  src_rm;
   logic [7:0]  src_arith;
   logic [7:0]  opnd;
   logic        is_sub;
   logic        use_cy;
   logic        cy;
   logic        cin;
   logic [8:0]  sum9;
   logic [4:0]  low5;
   logic [7:0]  step_r;
   logic        step_ac;
   logic [15:0] row_mod;
   logic [15:0] pair_r;
   logic [16:0] dad_sum;
   logic [7:0]  corr;
   logic        daa_cy;
   logic [7:0]  daa_r;
   logic [4:0]  daa_low;

   always_comb begin
      cy        = alu_in.flags[ebcpu_pkg::FLAG_CY];
      src_reg   = (alu_in.req.reg_sel == ebcpu_pkg::SEL_A) ? alu_in.acc :
                  (alu_in.req.reg_sel[0] ? alu_in.row_data[7:0] : alu_in.row_data[15:8]);
      src_rm    = (alu_in.req.reg_sel == ebcpu_pkg::SEL_M) ? alu_in.req.mem_data : src_reg;
      src_arith = alu_in.req.op[2] ? alu_in.req.immediate : src_rm;

      // add and subtract share one adder, subtract as a + ~op + carry
      is_sub = alu_in.req.op[1];
      use_cy = alu_in.req.op[0];
      opnd   = is_sub ? ~src_arith : src_arith;
      cin    = is_sub ? (use_cy ? ~cy : 1'b1) : (use_cy & cy);
      sum9   = {1'b0, alu_in.acc} + {1'b0, opnd} + {8'h00, cin};
      low5   = {1'b0, alu_in.acc[3:0]} + {1'b0, opnd[3:0]} + {4'h0, cin};

      // increment and decrement of one byte
      if (alu_in.req.op == ebcpu_pkg::OP_INR) begin
         step_r  = src_rm + 8'd1;
         step_ac = (src_rm[3:0] == 4'hf);
      end else begin
         step_r  = src_rm - 8'd1;
         step_ac = (src_rm[3:0] != 4'h0);
      end
      row_mod = alu_in.req.reg_sel[0] ? {alu_in.row_data[15:8], step_r}
                                      : {step_r, alu_in.row_data[7:0]};

      pair_r  = (alu_in.req.op == ebcpu_pkg::OP_INX) ? alu_in.row_data + 16'd1
                                                    : alu_in.row_data - 16'd1;
      dad_sum = {1'b0, alu_in.hl} + {1'b0, alu_in.row_data};

      // decimal adjust
      corr   = 8'h00;
      daa_cy = cy;
      if ((alu_in.acc[3:0] > 4'd9) || alu_in.flags[ebcpu_pkg::FLAG_AC]) begin
         corr[3:0] = 4'h6;
      end
      if ((alu_in.acc > 8'h99) || cy) begin
         corr[7:4] = 4'h6;
         daa_cy    = 1'b1;
      end
      daa_r   = alu_in.acc + corr;
      daa_low = {1'b0, alu_in.acc[3:0]} + {1'b0, corr[3:0]};

      alu_out           = '0;
      alu_out.acc       = alu_in.acc;
      alu_out.flags     = alu_in.flags;
      alu_out.hl        = alu_in.hl;
      alu_out.row_addr  = alu_in.req.reg_sel[2:1];
      alu_out.row_data  = alu_in.row_data;

      case (alu_in.req.op) inside
         ebcpu_pkg::OP_ADD, ebcpu_pkg::OP_ADC, ebcpu_pkg::OP_ADI, ebcpu_pkg::OP_ACI,
         ebcpu_pkg::OP_SUB, ebcpu_pkg::OP_SBB, ebcpu_pkg::OP_SUI, ebcpu_pkg::OP_SBI: begin
            alu_out.acc   = sum9[7:0];
            alu_out.flags = ebcpu_pkg::szp_flags(sum9[7:0]);
            alu_out.flags[ebcpu_pkg::FLAG_CY] = sum9[8] ^ is_sub;
            alu_out.flags[ebcpu_pkg::FLAG_AC] = low5[4];
         end
         ebcpu_pkg::OP_INR, ebcpu_pkg::OP_DCR: begin
            alu_out.flags = ebcpu_pkg::szp_flags(step_r);
            alu_out.flags[ebcpu_pkg::FLAG_AC] = step_ac;
            alu_out.flags[ebcpu_pkg::FLAG_CY] = cy;
            if (alu_in.req.reg_sel == ebcpu_pkg::SEL_M) begin
               alu_out.mem_write = 1'b1;
               alu_out.mem_wdata = step_r;
            end else if (alu_in.req.reg_sel == ebcpu_pkg::SEL_A) begin
               alu_out.acc = step_r;
            end else begin
               alu_out.row_we   = 1'b1;
               alu_out.row_data = row_mod;
               if (alu_in.req.reg_sel[2:1] == ebcpu_pkg::PAIR_HL) begin
                  alu_out.hl = row_mod;
               end
            end
         end
         ebcpu_pkg::OP_INX, ebcpu_pkg::OP_DCX: begin
            if (alu_in.req.pair_sel == ebcpu_pkg::PAIR_BAD) begin
               alu_out.error = 1'b1;
            end else begin
               alu_out.row_we   = 1'b1;
               alu_out.row_addr = alu_in.req.pair_sel;
               alu_out.row_data = pair_r;
               if (alu_in.req.pair_sel == ebcpu_pkg::PAIR_HL) begin
                  alu_out.hl = pair_r;
               end
            end
         end
         ebcpu_pkg::OP_DAD: begin
            if (alu_in.req.pair_sel == ebcpu_pkg::PAIR_BAD) begin
               alu_out.error = 1'b1;
            end else begin
               alu_out.row_we   = 1'b1;
               alu_out.row_addr = ebcpu_pkg::PAIR_HL;
               alu_out.row_data = dad_sum[15:0];
               alu_out.hl       = dad_sum[15:0];
               alu_out.flags[ebcpu_pkg::FLAG_CY] = dad_sum[16];
            end
         end
         ebcpu_pkg::OP_DAA: begin
            alu_out.acc   = daa_r;
            alu_out.flags = ebcpu_pkg::szp_flags(daa_r);
            alu_out.flags[ebcpu_pkg::FLAG_CY] = daa_cy;
            alu_out.flags[ebcpu_pkg::FLAG_AC] = daa_low[4];
         end
         default: begin
            alu_out.error = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/ebcpu_checker.sv
// port checker of the 8-bit cpu arithmetic group and its bind
`default_nettype none

module ebcpu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [31:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata))
      else $error("result payload changed while stalled");

   // an error item never writes memory
   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[38]) |-> !rsp_tdata[13])
      else $error("memory write on error item");

   // write data is zero without a write
   a_wdata_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[13]) |-> (rsp_tdata[21:14] == 8'h00))
      else $error("write data without memory write");

endmodule

bind eight_bit_cpu_arith_group ebcpu_checker u_ebcpu_checker (.*);

`default_nettype wire
